// ===== rtl/core/rwt_pkg.sv =====
// Shared types and constants for the reference weight table.
// Used by rwt_ctrl, rwt_dp and the reference_weight_table top level.
package rwt_pkg;

  localparam int TABLE_DEPTH   = 8;
  localparam int MAX_LEVEL     = 255;
  localparam int MAX_NUMERATOR = 134217727;

  localparam int NUM_W  = 27;
  localparam int LVL_W  = 8;
  localparam int DIV_W  = 16;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int BIT_W  = $clog2(NUM_W);
  localparam int ADDR_W = 3;

  localparam logic [NUM_W-1:0]  NUM_MAX = NUM_W'(MAX_NUMERATOR);
  localparam logic [ADDR_W-1:0] ADDR_SPLIT_DIVISOR = ADDR_W'(0);
  localparam logic [DIV_W-1:0]  DIVISOR_RESET = DIV_W'(2);

  typedef enum logic [1:0] {
    KIND_ISSUE = 2'd0,
    KIND_MERGE = 2'd1,
    KIND_DROP  = 2'd2,
    KIND_INIT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [NUM_W-1:0]  in_num;
    logic [LVL_W-1:0]  in_level;
  } item_t;

  typedef struct packed {
    logic [NUM_W-1:0]  out_num;
    logic [LVL_W-1:0]  out_level;
    logic              pair_valid;
    logic              last;
    logic              table_empty;
    logic              overflow;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DIV,
    S_APPLY,
    S_MERGE_CHK,
    S_MERGE,
    S_DROP,
    S_INIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ISSUE_APPLY,
    OP_SCAN_NEXT,
    OP_MERGE_ACT,
    OP_DROP_EMIT,
    OP_INIT_LOAD,
    OP_EMIT_OK,
    OP_EMIT_OVF
  } dp_op_t;

  typedef enum logic [1:0] {
    ISS_HEAD,
    ISS_SPLIT,
    ISS_STEAL
  } iss_case_t;

  typedef struct packed {
    logic iss_ovf;
    logic div_last;
    logic in_bad;
    logic in_zero;
    logic scan_hit;
    logic act_fin;
    logic cnt_zero;
    logic cnt_one;
  } dp_stat_t;

endpackage

// ===== rtl/core/reference_weight_table.sv =====
// Top level of the reference weight table: configuration port, controller
// and datapath. Depends on rwt_pkg, rwt_ctrl and rwt_dp.
//
// Usage: present an item on item and raise start; it is taken at a clock edge
// where start is high and busy is low. Results appear on result for one cycle
// each, marked by strobe; the receiver cannot stall them. last marks the
// final result of an item.
// Issue work is dominated by the 27-step serial divider by split_divisor; a merge
// scans the table entries once per carry level; drop gives one result per cycle.
// One item is in work at a time, busy stays high until its last result.
// split_divisor is written through the APB port at address 0; the user must
// write it only while idle, which the block itself does not enforce;
// a value of 0 acts as 1.
// Reset (rst, synchronous) empties the table, sets split_divisor to 2 and
// returns to idle; no clearing pass is needed.
module reference_weight_table import rwt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  output logic              strobe,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [DIV_W-1:0] split_divisor;
  dp_op_t           op;
  dp_stat_t         stat;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SPLIT_DIVISOR) ? {{(32-DIV_W){1'b0}}, split_divisor} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_divisor <= DIVISOR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_SPLIT_DIVISOR) begin
      split_divisor <= pwdata[DIV_W-1:0];
    end
  end

  rwt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .stat  (stat),
    .busy  (busy),
    .op    (op)
  );

  rwt_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .item   (item),
    .alpha  (split_divisor),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ===== rtl/core/rwt_dp.sv =====
// Datapath of the reference weight table: pair table, backup copy,
// serial divider and result register. Depends on rwt_pkg.
module rwt_dp import rwt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dp_op_t           op,
  input  item_t            item,
  input  logic [DIV_W-1:0] alpha,
  output dp_stat_t         stat,
  output logic             strobe,
  output result_t          result
);

  logic [NUM_W-1:0] num  [TABLE_DEPTH];
  logic [LVL_W-1:0] lvl  [TABLE_DEPTH];
  logic [NUM_W-1:0] bnum [TABLE_DEPTH];
  logic [LVL_W-1:0] blvl [TABLE_DEPTH];
  logic [CNT_W-1:0] cnt, bcnt;

  logic [NUM_W-1:0] e_r;
  logic [LVL_W-1:0] k_r;
  logic [CNT_W-1:0] idx;
  iss_case_t        case_r;
  logic [NUM_W-1:0] quot;
  logic [DIV_W-1:0] rem;
  logic [BIT_W-1:0] bitcnt;

  logic [DIV_W-1:0] a_eff;
  logic [DIV_W:0]   trial;
  logic             head_gt1, split_ok;
  logic [LVL_W:0]   lvl0p;
  logic [NUM_W-1:0] share, iss_cur, iss_left;
  logic [LVL_W-1:0] iss_lvl;
  logic [IDX_W-1:0] iss_sel, idx_i;
  logic             iss_rm;
  logic [NUM_W-1:0] cur_n;
  logic [LVL_W-1:0] cur_l;
  logic             at_end, need_ins, m_ovf;
  logic [NUM_W:0]   s;
  logic             s_lt, s_eq;
  logic             emit;
  result_t          res_next;

  assign a_eff    = (alpha == '0) ? DIV_W'(1) : alpha;
  assign trial    = {rem, quot[NUM_W-1]};
  assign head_gt1 = num[0] > NUM_W'(1);
  assign lvl0p    = {1'b0, lvl[0]} + (LVL_W+1)'(1);
  assign split_ok = (cnt < CNT_W'(2)) || ({1'b0, lvl[1]} > lvl0p);

  assign share    = (quot == '0) ? NUM_W'(1) : quot;
  assign iss_cur  = (case_r == ISS_SPLIT) ? NUM_MAX :
                    (case_r == ISS_STEAL) ? num[1] : num[0];
  assign iss_left = iss_cur - share;
  assign iss_rm   = iss_left == '0;
  assign iss_sel  = (case_r == ISS_STEAL) ? IDX_W'(1) : IDX_W'(0);
  assign iss_lvl  = (case_r == ISS_SPLIT) ? lvl0p[LVL_W-1:0] :
                    (case_r == ISS_STEAL) ? lvl[1] : lvl[0];

  assign idx_i    = idx[IDX_W-1:0];
  assign cur_n    = num[idx_i];
  assign cur_l    = lvl[idx_i];
  assign at_end   = idx == cnt;
  assign need_ins = at_end || (cur_l > k_r);
  assign m_ovf    = need_ins && (cnt >= CNT_W'(TABLE_DEPTH));
  assign s        = {1'b0, cur_n} + {1'b0, e_r};
  assign s_lt     = s < {1'b0, NUM_MAX};
  assign s_eq     = s == {1'b0, NUM_MAX};

  always_comb begin
    stat.iss_ovf  = !head_gt1 && split_ok && (int'(lvl0p) > MAX_LEVEL);
    stat.div_last = bitcnt == BIT_W'(NUM_W - 1);
    stat.in_bad   = (int'(k_r) > MAX_LEVEL) || (e_r > NUM_MAX);
    stat.in_zero  = (k_r == '0) || (e_r == '0);
    stat.scan_hit = at_end || (cur_l >= k_r);
    stat.act_fin  = need_ins || s_lt || (k_r == LVL_W'(1));
    stat.cnt_zero = cnt == '0;
    stat.cnt_one  = cnt == CNT_W'(1);
  end

  always_comb begin
    emit     = 1'b0;
    res_next = '0;
    res_next.last = 1'b1;
    res_next.table_empty = cnt == '0;
    case (op)
      OP_ISSUE_APPLY: begin
        emit = 1'b1;
        res_next.out_num     = share;
        res_next.out_level   = iss_lvl;
        res_next.pair_valid  = 1'b1;
        res_next.table_empty = iss_rm && (cnt == CNT_W'(1));
      end
      OP_MERGE_ACT: begin
        emit = m_ovf || stat.act_fin;
        res_next.overflow = m_ovf;
        if (m_ovf) begin
          res_next.table_empty = bcnt == '0;
        end else if (need_ins) begin
          res_next.table_empty = 1'b0;
        end else begin
          res_next.table_empty = s_eq && (cnt == CNT_W'(1));
        end
      end
      OP_DROP_EMIT: begin
        emit = 1'b1;
        res_next.out_num     = num[0];
        res_next.out_level   = lvl[0];
        res_next.pair_valid  = 1'b1;
        res_next.last        = cnt == CNT_W'(1);
        res_next.table_empty = 1'b1;
      end
      OP_INIT_LOAD: begin
        emit = 1'b1;
        res_next.table_empty = stat.in_zero;
      end
      OP_EMIT_OK: begin
        emit = 1'b1;
      end
      OP_EMIT_OVF: begin
        emit = 1'b1;
        res_next.overflow = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
      result <= res_next;
      case (op)
        OP_ACCEPT: begin
          e_r  <= item.in_num;
          k_r  <= item.in_level;
          idx  <= '0;
          bnum <= num;
          blvl <= lvl;
          bcnt <= cnt;
          // an empty table starts from the whole weight
          if (item.kind == KIND_ISSUE && cnt == '0) begin
            num[0] <= NUM_MAX;
            lvl[0] <= LVL_W'(1);
            cnt    <= CNT_W'(1);
          end
        end
        OP_DIV_INIT: begin
          quot   <= head_gt1 ? num[0] : (split_ok ? NUM_MAX : num[1]);
          case_r <= head_gt1 ? ISS_HEAD : (split_ok ? ISS_SPLIT : ISS_STEAL);
          rem    <= '0;
          bitcnt <= '0;
        end
        OP_DIV_STEP: begin
          bitcnt <= bitcnt + BIT_W'(1);
          if (trial >= {1'b0, a_eff}) begin
            rem  <= DIV_W'(trial - {1'b0, a_eff});
            quot <= {quot[NUM_W-2:0], 1'b1};
          end else begin
            rem  <= trial[DIV_W-1:0];
            quot <= {quot[NUM_W-2:0], 1'b0};
          end
        end
        OP_ISSUE_APPLY: begin
          if (iss_rm) begin
            for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
              if (j >= int'(iss_sel)) begin
                num[j] <= num[j+1];
                lvl[j] <= lvl[j+1];
              end
            end
            cnt <= cnt - CNT_W'(1);
          end else begin
            num[iss_sel] <= iss_left;
            lvl[iss_sel] <= iss_lvl;
          end
        end
        OP_SCAN_NEXT: begin
          idx <= idx + CNT_W'(1);
        end
        OP_MERGE_ACT: begin
          if (m_ovf) begin
            // roll back any carries already applied
            num <= bnum;
            lvl <= blvl;
            cnt <= bcnt;
          end else if (need_ins) begin
            for (int j = 1; j < TABLE_DEPTH; j++) begin
              if (j > int'(idx_i)) begin
                num[j] <= num[j-1];
                lvl[j] <= lvl[j-1];
              end
            end
            num[idx_i] <= e_r;
            lvl[idx_i] <= k_r;
            cnt <= cnt + CNT_W'(1);
          end else if (s_lt) begin
            num[idx_i] <= s[NUM_W-1:0];
          end else begin
            if (s_eq) begin
              for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
                if (j >= int'(idx_i)) begin
                  num[j] <= num[j+1];
                  lvl[j] <= lvl[j+1];
                end
              end
              cnt <= cnt - CNT_W'(1);
            end else begin
              num[idx_i] <= NUM_W'(s - {1'b0, NUM_MAX});
            end
            // carry one unit into the next level up
            e_r <= NUM_W'(1);
            k_r <= k_r - LVL_W'(1);
            idx <= '0;
          end
        end
        OP_DROP_EMIT: begin
          for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
            num[j] <= num[j+1];
            lvl[j] <= lvl[j+1];
          end
          cnt <= cnt - CNT_W'(1);
        end
        OP_INIT_LOAD: begin
          if (stat.in_zero) begin
            cnt <= '0;
          end else begin
            num[0] <= e_r;
            lvl[0] <= k_r;
            cnt    <= CNT_W'(1);
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("pair count beyond table depth");

  a_valid_no_ovf: assert property (@(posedge clk) disable iff (rst)
    strobe && result.pair_valid |-> !result.overflow)
    else $error("pair emitted with overflow");

  a_drop_cont: assert property (@(posedge clk) disable iff (rst)
    strobe && result.pair_valid && !result.last |=> strobe && result.pair_valid)
    else $error("drop sequence broken");

endmodule

// ===== rtl/core/rwt_ctrl.sv =====
// Controller of the reference weight table: sequences datapath operations
// per item kind. Depends on rwt_pkg.
module rwt_ctrl import rwt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  kind_t    kind,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_op_t   op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          op = OP_ACCEPT;
          case (kind)
            KIND_ISSUE: state_next = S_ISSUE;
            KIND_MERGE: state_next = S_MERGE_CHK;
            KIND_DROP:  state_next = S_DROP;
            default:    state_next = S_INIT;
          endcase
        end
      end
      S_ISSUE: begin
        if (stat.iss_ovf) begin
          op = OP_EMIT_OVF;
          state_next = S_IDLE;
        end else begin
          op = OP_DIV_INIT;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        op = OP_ISSUE_APPLY;
        state_next = S_IDLE;
      end
      S_MERGE_CHK: begin
        if (stat.in_bad) begin
          op = OP_EMIT_OVF;
          state_next = S_IDLE;
        end else if (stat.in_zero) begin
          op = OP_EMIT_OK;
          state_next = S_IDLE;
        end else begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        if (!stat.scan_hit) begin
          op = OP_SCAN_NEXT;
        end else begin
          op = OP_MERGE_ACT;
          if (stat.act_fin) begin
            state_next = S_IDLE;
          end
        end
      end
      S_DROP: begin
        if (stat.cnt_zero) begin
          op = OP_EMIT_OK;
          state_next = S_IDLE;
        end else begin
          op = OP_DROP_EMIT;
          if (stat.cnt_one) begin
            state_next = S_IDLE;
          end
        end
      end
      S_INIT: begin
        op = stat.in_bad ? OP_EMIT_OVF : OP_INIT_LOAD;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_op_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |-> op == OP_NONE)
    else $error("datapath op issued while idle");

  a_div_then_apply: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && stat.div_last |=> state == S_APPLY)
    else $error("divider end not followed by apply");

endmodule
